// ----- src/bmhpq_pkg.sv -----
// Shared types and codes for the binary min-heap priority queue.
// No dependencies; imported by the top level.
package bmhpq_pkg;

   localparam int OP_W     = 1;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 11;
   localparam int KEY_W    = 32;

   localparam logic [OP_W-1:0] OP_INSERT  = 1'b0;
   localparam logic [OP_W-1:0] OP_EXTRACT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 11'd1024;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP,
      S_EX_ROOT,
      S_EX_LAST,
      S_DN_L,
      S_DN_R,
      S_PLACE,
      S_RESP
   } state_type;

endpackage

// ----- src/bmhpq_ram.sv -----
// Simple dual-port heap store: one write port, one read port, registered read data.
// No dependencies.
module bmhpq_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/binary_min_heap_priority_queue.sv -----
// Binary min-heap priority queue: sequencer, count, capacity and result register.
// Depends on bmhpq_pkg and bmhpq_ram.
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | req_operation, req_value
//  rsp     | out       | rsp_valid/stall   | rsp_min_value, rsp_status, rsp_entry_count
//  csr     | in        | csr_valid/ready   | csr_capacity
//
// One item at a time: req_stall holds while an item is in progress. An insert
// moves the new key up level by level and an extract moves the last key down
// level by level, paced by the single read port of the heap store: one child
// read per cycle. The next item is taken the cycle after the result register
// is loaded.
// Reset clears the count and sets capacity to 1024; the store needs no clearing.
// A stalled result waits in the output register while the next item is taken.
module binary_min_heap_priority_queue
   import bmhpq_pkg::*;
#(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic signed [KEY_W-1:0] req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [KEY_W-1:0] rsp_min_value,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [CAP_W-1:0]    rsp_entry_count,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CAP_W-1:0]    csr_capacity
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] POS_ONE = CW'(1);

   state_type state_ff, state_in;

   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         pos_ff, pos_in;
   logic [CW-1:0]         child_ff, child_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic [DATA_WIDTH-1:0] left_ff, left_in;
   logic [DATA_WIDTH-1:0] root_ff, root_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [CAP_W-1:0]      capacity_ff, capacity_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]      rsp_min_value_ff, rsp_min_value_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [CAP_W-1:0]      rsp_entry_count_ff, rsp_entry_count_in;

   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;

   logic                  req_take, full, out_free;
   logic [CW-1:0]         parent;
   logic [DATA_WIDTH-1:0] sel_val;
   logic [CW-1:0]         sel_pos;
   logic [CW:0]           grand;

   bmhpq_ram #(
      .DEPTH (DEPTH),
      .WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign full      = (CMPW'(count_ff) >= CMPW'(capacity_ff)) || (count_ff == DEPTH_C);
   assign parent    = pos_ff >> 1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_min_value   = rsp_min_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

   // smaller child on the way down; left wins a tie
   always_comb begin
      if (state_ff == S_DN_R && $signed(rd_data) < $signed(left_ff)) begin
         sel_val = rd_data;
         sel_pos = child_ff + POS_ONE;
      end else if (state_ff == S_DN_R) begin
         sel_val = left_ff;
         sel_pos = child_ff;
      end else begin
         sel_val = rd_data;
         sel_pos = child_ff;
      end
      grand = {sel_pos, 1'b0};
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      child_in    = child_ff;
      key_in      = key_ff;
      left_in     = left_ff;
      root_in     = root_ff;
      status_in   = status_ff;
      capacity_in = csr_valid ? csr_capacity : capacity_ff;
      wr_en       = 1'b0;
      wr_addr     = AW'(pos_ff - POS_ONE);
      wr_data     = key_ff;
      rd_en       = 1'b0;
      rd_addr     = '0;

      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_min_value_in   = rsp_min_value_ff;
      rsp_status_in      = rsp_status_ff;
      rsp_entry_count_in = rsp_entry_count_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               root_in   = '0;
               status_in = STATUS_OK;
               state_in  = S_RESP;
               if (req_operation == OP_INSERT) begin
                  if (full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     count_in = count_ff + POS_ONE;
                     pos_in   = count_ff + POS_ONE;
                     key_in   = DATA_WIDTH'(req_value);
                     if (count_ff == '0) begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = DATA_WIDTH'(req_value);
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(((count_ff + POS_ONE) >> 1) - POS_ONE);
                        state_in = S_UP;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     count_in = count_ff - POS_ONE;
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = S_EX_ROOT;
                  end
               end
            end
         end
         S_UP: begin
            if ($signed(key_ff) < $signed(rd_data)) begin
               // parent moves down into the hole
               wr_en   = 1'b1;
               wr_data = rd_data;
               pos_in  = parent;
               if (parent > POS_ONE) begin
                  rd_en   = 1'b1;
                  rd_addr = AW'((parent >> 1) - POS_ONE);
               end else begin
                  state_in = S_PLACE;
               end
            end else begin
               wr_en    = 1'b1;
               state_in = S_RESP;
            end
         end
         S_EX_ROOT: begin
            root_in  = rd_data;
            rd_en    = 1'b1;
            rd_addr  = AW'(count_ff);
            state_in = S_EX_LAST;
         end
         S_EX_LAST: begin
            key_in = rd_data;
            pos_in = POS_ONE;
            if (count_ff == '0) begin
               state_in = S_RESP;
            end else if (count_ff > POS_ONE) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(1);
               child_in = CW'(2);
               state_in = S_DN_L;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = rd_data;
               state_in = S_RESP;
            end
         end
         S_DN_L, S_DN_R: begin
            if (state_ff == S_DN_L && child_ff < count_ff) begin
               // fetch the right child before deciding
               left_in  = rd_data;
               rd_en    = 1'b1;
               rd_addr  = AW'(child_ff);
               state_in = S_DN_R;
            end else if ($signed(sel_val) < $signed(key_ff)) begin
               wr_en   = 1'b1;
               wr_data = sel_val;
               pos_in  = sel_pos;
               if (grand <= {1'b0, count_ff}) begin
                  rd_en    = 1'b1;
                  rd_addr  = AW'(grand - {1'b0, POS_ONE});
                  child_in = CW'(grand);
                  state_in = S_DN_L;
               end else begin
                  state_in = S_PLACE;
               end
            end else begin
               wr_en    = 1'b1;
               state_in = S_RESP;
            end
         end
         S_PLACE: begin
            wr_en    = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_min_value_in   = KEY_W'($signed(root_ff));
               rsp_status_in      = status_ff;
               rsp_entry_count_in = CAP_W'(count_ff);
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff             <= pos_in;
      child_ff           <= child_in;
      key_ff             <= key_in;
      left_ff            <= left_in;
      root_ff            <= root_in;
      status_ff          <= status_in;
      rsp_min_value_ff   <= rsp_min_value_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
   end

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for binary_min_heap_priority_queue: a heap scoreboard
// predicts every result, plain tasks drive requests and capacity writes.
// Depends on bmhpq_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
   import bmhpq_pkg::*;

   localparam int HEAP_DEPTH  = 1024;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 60;

   typedef struct {
      logic signed [KEY_W-1:0] min_value;
      logic [STATUS_W-1:0]     status;
      logic [CAP_W-1:0]        entry_count;
   } heap_result_type;

   class heap_scoreboard_type;
      logic signed [KEY_W-1:0] heap_keys [1:HEAP_DEPTH];
      int unsigned             fill;
      logic [CAP_W-1:0]        cap_reg;
      heap_result_type         expected_results [$];
      int                      errors;

      function new();
         fill    = 0;
         cap_reg = CAPACITY_RESET;
         errors  = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] value);
         cap_reg = value;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void swap_keys(int unsigned a, int unsigned b);
         logic signed [KEY_W-1:0] t;
         t            = heap_keys[a];
         heap_keys[a] = heap_keys[b];
         heap_keys[b] = t;
      endfunction

      // Run one operation on the predicted heap and queue its result.
      function void note_request(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key);
         heap_result_type r;
         int unsigned     eff_cap;
         int unsigned     i;
         int unsigned     c;
         bit              settled;
         r.min_value = '0;
         r.status    = STATUS_OK;
         eff_cap     = (cap_reg > HEAP_DEPTH) ? HEAP_DEPTH : cap_reg;
         if (op == OP_INSERT) begin
            if (fill >= eff_cap) begin
               r.status = STATUS_FULL;
            end else begin
               fill++;
               heap_keys[fill] = key;
               i = fill;
               while (i > 1 && heap_keys[i] < heap_keys[i/2]) begin
                  swap_keys(i, i/2);
                  i = i / 2;
               end
            end
         end else begin
            if (fill == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.min_value  = heap_keys[1];
               heap_keys[1] = heap_keys[fill];
               fill--;
               i       = 1;
               c       = 2;
               settled = 1'b0;
               while (c <= fill && !settled) begin
                  // take the left child on a tie
                  if (c + 1 <= fill && heap_keys[c+1] < heap_keys[c]) c++;
                  if (!(heap_keys[c] < heap_keys[i])) begin
                     settled = 1'b1;
                  end else begin
                     swap_keys(c, i);
                     i = c;
                     c = 2 * i;
                  end
               end
            end
         end
         r.entry_count    = CAP_W'(fill);
         expected_results = {expected_results, r};
      endfunction

      function void report(string field, longint exp_val, longint act_val);
         if (errors < PRINT_LIMIT)
            $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
         errors++;
      endfunction

      function void check_result(logic signed [KEY_W-1:0] min_value,
                                 logic [STATUS_W-1:0] status,
                                 logic [CAP_W-1:0] entry_count);
         heap_result_type r;
         if (expected_results.size() == 0) begin
            if (errors < PRINT_LIMIT)
               $error("unexpected result transfer: min_value %0d status %0d entry_count %0d",
                      min_value, status, entry_count);
            errors++;
         end else begin
            r = expected_results.pop_front();
            if (min_value !== r.min_value) report("min_value", r.min_value, min_value);
            if (status !== r.status) report("status", r.status, status);
            if (entry_count !== r.entry_count)
               report("entry_count", r.entry_count, entry_count);
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [OP_W-1:0]         req_operation = OP_INSERT;
   logic signed [KEY_W-1:0] req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [KEY_W-1:0] rsp_min_value;
   logic [STATUS_W-1:0]     rsp_status;
   logic [CAP_W-1:0]        rsp_entry_count;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CAP_W-1:0]        csr_capacity = '0;

   heap_scoreboard_type sb = new();
   int                  cycle_count = 0;
   int                  burst_left = 0;
   int                  stall_mode = 0;
   int                  stall_left = 0;

   binary_min_heap_priority_queue DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_min_value   (rsp_min_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_capacity    (csr_capacity)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Observe every transfer at the edge; check results before noting new requests.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_capacity(csr_capacity);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_min_value, rsp_status, rsp_entry_count);
         if (req_valid && !req_stall) sb.note_request(req_operation, req_value);
      end
   end

   // Receiver stall pattern: switch between free-running, light, heavy and toggling.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 80);
         end else begin
            stall_left = stall_left - 1;
         end
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 99) < 25);
            end
            2: begin
               rsp_stall <= ($urandom_range(0, 99) < 75);
            end
            default: begin
               rsp_stall <= ~rsp_stall;
            end
         endcase
      end
   end

   function automatic logic signed [KEY_W-1:0] random_key();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         return KEY_W'($signed($urandom_range(0, 16)) - 8);
      end else if (pick < 45) begin
         case ($urandom_range(0, 3))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            default: return -32'sd1;
         endcase
      end else begin
         return $urandom;
      end
   endfunction

   task automatic send_item(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= key;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid for a random gap between bursts.
   task automatic pace_sender();
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
      end
      burst_left--;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      csr_valid    <= 1'b1;
      csr_capacity <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(logic [CAP_W-1:0] capacity, int items, int insert_pct);
      write_capacity(capacity);
      repeat (items) begin
         pace_sender();
         if ($urandom_range(0, 99) < insert_pct) send_item(OP_INSERT, random_key());
         else send_item(OP_EXTRACT, $urandom);
      end
      wait_idle();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty extract, extreme and equal keys, then drain past empty.
      write_capacity(11'd1024);
      send_item(OP_EXTRACT, 32'sh1234_5678);
      send_item(OP_INSERT, 32'sh7FFF_FFFF);
      send_item(OP_INSERT, 32'sh8000_0000);
      send_item(OP_INSERT, 32'sh0000_0000);
      send_item(OP_INSERT, -32'sd1);
      send_item(OP_INSERT, 32'sd1);
      send_item(OP_INSERT, 32'sd5);
      send_item(OP_INSERT, 32'sd5);
      send_item(OP_INSERT, 32'sd5);
      send_item(OP_INSERT, 32'sh5555_5555);
      send_item(OP_INSERT, 32'shAAAA_AAAA);
      repeat (11) send_item(OP_EXTRACT, $urandom);
      wait_idle();

      // Directed: single-entry capacity, overflow then underflow.
      write_capacity(11'd1);
      send_item(OP_INSERT, 32'sd7);
      send_item(OP_INSERT, 32'sd3);
      send_item(OP_EXTRACT, 32'sd0);
      send_item(OP_EXTRACT, 32'sd0);
      wait_idle();

      // Random phases; capacity is lowered below the count between them.
      run_phase(11'd2047, 100, 75);
      run_phase(11'd8, 100, 30);
      run_phase(11'd0, 30, 50);
      run_phase(11'd1024, 200, 70);
      run_phase(11'd3, 30, 40);
      run_phase(11'd1024, 120, 35);
      run_phase(CAP_W'($urandom_range(1, 16)), 80, 55);
      run_phase(11'd2, 40, 60);

      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/bmhpq_pkg.sv
src/bmhpq_ram.sv
src/binary_min_heap_priority_queue.sv
dv/tb_top.sv
